[hw/rtl/crcr_pkg.sv]
// Shared types, command codes and constants of the card reader command responder.
`default_nettype none

package crcr_pkg;

  localparam int VERSION_BYTES = 44;
  localparam int IDX_W = $clog2(VERSION_BYTES);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] CMD_VERSION = 16'h0002;
  localparam logic [15:0] CMD_RESET = 16'h0003;
  localparam logic [15:0] CMD_ACK = 16'h0080;
  localparam logic [15:0] CMD_POLL_A = 16'h0131;
  localparam logic [15:0] CMD_POLL_B = 16'h0134;
  localparam logic [15:0] CMD_POLL_CTRL = 16'h0135;

  localparam logic [7:0] CTRL_REFUSE = 8'h00;
  localparam logic [7:0] CTRL_ACCEPT = 8'h11;
  localparam logic [7:0] CTRL_EJECT = 8'h12;

  localparam logic [7:0] UNIT_ONE = 8'd1;
  localparam logic [7:0] UNIT_TWO = 8'd2;

  localparam logic [7:0] SENSOR_CARD = 8'h30;
  localparam logic [7:0] EVENT_STEP = 8'h10;
  localparam logic [7:0] EVENT_NIBBLE = 8'hf0;
  localparam logic [7:0] EVENT_FLAG = 8'h80;

  typedef struct packed {
    logic [15:0] command_code;
    logic [7:0]  control_byte;
    logic [7:0]  unit_address;
    logic [11:0] keys_one;
    logic [11:0] keys_two;
  } command_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    KIND_VERSION,
    KIND_ACK,
    KIND_ZERO,
    KIND_STATUS
  } kind_t;

  // One classified command as handed from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic        card_in;
    logic        sensor;
    logic [63:0] card_id;
    logic [7:0]  newest_event;
    logic [7:0]  older_event;
  } desc_t;

endpackage

`default_nettype wire

[hw/rtl/crcr_front.sv]
// Front end: accepts commands, keeps the reader state and classifies each command.
`default_nettype none

module crcr_front
  import crcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire command_t    cmd,
  input  wire logic [63:0] card_id,
  input  wire logic        q_full,
  output logic             full,
  output logic             q_push,
  output desc_t            q_data
);

  // Key code of bits 0 to 10 of a keypad vector.
  localparam logic [10:0][4:0] KEY_CODES = {
    5'h04, 5'h0b, 5'h07, 5'h03, 5'h0a, 5'h06, 5'h02, 5'h09, 5'h05, 5'h01, 5'h10
  };

  logic       accepting, card_in, insert_held;
  logic [4:0] previous_key_code;
  logic [7:0] newest_event, older_event;

  logic       accepting_next, card_in_next, insert_held_next;
  logic [4:0] previous_key_code_next;
  logic [7:0] newest_event_next, older_event_next;

  logic        accept, is_status;
  logic        acc1, cin1, held1;
  logic [11:0] keys;
  logic [4:0]  cur;
  logic        insert_now;
  logic [7:0]  ev;
  kind_t       kind;

  assign full = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  assign is_status = (cmd.command_code == CMD_POLL_A) || (cmd.command_code == CMD_POLL_B)
                     || (cmd.command_code == CMD_POLL_CTRL);

  always_comb begin
    acc1 = accepting;
    cin1 = card_in;
    held1 = insert_held;
    if (cmd.command_code == CMD_POLL_CTRL) begin
      case (cmd.control_byte)
        CTRL_REFUSE: acc1 = 1'b0;
        CTRL_ACCEPT: acc1 = 1'b1;
        CTRL_EJECT: begin
          acc1 = 1'b0;
          cin1 = 1'b0;
          held1 = 1'b0;
        end
        default: ;
      endcase
    end

    // An unknown unit presses nothing, which is all ones in active-low form.
    if (cmd.unit_address == UNIT_ONE) begin
      keys = cmd.keys_one;
    end else if (cmd.unit_address == UNIT_TWO) begin
      keys = cmd.keys_two;
    end else begin
      keys = '1;
    end

    cur = '0;
    for (int i = 0; i < 11; i++) begin
      if (!keys[i]) cur = cur | KEY_CODES[i];
    end
    insert_now = !keys[11];

    ev = '0;
    if (newest_event != '0) ev = (newest_event + EVENT_STEP) & EVENT_NIBBLE;
    ev = ev | EVENT_FLAG | {3'b000, cur};
  end

  always_comb begin
    accepting_next = accepting;
    card_in_next = card_in;
    insert_held_next = insert_held;
    previous_key_code_next = previous_key_code;
    newest_event_next = newest_event;
    older_event_next = older_event;
    if (accept && is_status) begin
      accepting_next = acc1;
      card_in_next = cin1;
      insert_held_next = held1;
      if (insert_now) begin
        if (!held1) begin
          if (acc1 || cin1) card_in_next = !cin1;
          insert_held_next = 1'b1;
        end
      end else begin
        insert_held_next = 1'b0;
      end
      // A bit of the key code that was not set at the last poll makes a new event.
      if ((cur & (previous_key_code ^ cur)) != '0) begin
        older_event_next = newest_event;
        newest_event_next = ev;
      end
      previous_key_code_next = cur;
    end else if (accept && cmd.command_code == CMD_RESET) begin
      accepting_next = 1'b0;
      card_in_next = 1'b0;
      insert_held_next = 1'b0;
      previous_key_code_next = '0;
      newest_event_next = '0;
      older_event_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepting <= 1'b0;
      card_in <= 1'b0;
      insert_held <= 1'b0;
      previous_key_code <= '0;
      newest_event <= '0;
      older_event <= '0;
    end else begin
      accepting <= accepting_next;
      card_in <= card_in_next;
      insert_held <= insert_held_next;
      previous_key_code <= previous_key_code_next;
      newest_event <= newest_event_next;
      older_event <= older_event_next;
    end
  end

  always_comb begin
    if (cmd.command_code == CMD_VERSION) begin
      kind = KIND_VERSION;
    end else if (cmd.command_code == CMD_ACK) begin
      kind = KIND_ACK;
    end else if (is_status) begin
      kind = KIND_STATUS;
    end else begin
      kind = KIND_ZERO;
    end
    q_data.kind = kind;
    q_data.card_in = card_in_next;
    q_data.sensor = accepting_next && card_in_next;
    q_data.card_id = card_in_next ? card_id : '0;
    q_data.newest_event = newest_event_next;
    q_data.older_event = older_event_next;
  end

endmodule

`default_nettype wire

[hw/rtl/crcr_queue.sv]
// Short register queue of classified commands between the front and the back.
`default_nettype none

module crcr_queue
  import crcr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire desc_t wr_data,
  input  wire logic  rd,
  output logic       full,
  output logic       valid,
  output desc_t      rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  desc_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/crcr_back.sv]
// Back end: walks each classified command and emits its response bytes into an output register.
`default_nettype none

module crcr_back
  import crcr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire desc_t q_data,
  output logic       q_pop,
  input  wire logic  pop,
  output logic       empty,
  output result_t    result
);

  localparam logic [IDX_W-1:0] VERSION_LAST = IDX_W'(VERSION_BYTES - 1);
  localparam logic [IDX_W-1:0] STATUS_LAST = IDX_W'(15);

  localparam logic [7:0] VERSION_TABLE [VERSION_BYTES] = '{
    8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00,
    8'h49, 8'h43, 8'h43, 8'h41,
    8'h4f, 8'h63, 8'h74, 8'h20, 8'h32, 8'h36, 8'h20, 8'h32,
    8'h30, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h31, 8'h33, 8'h20, 8'h3a, 8'h20, 8'h35, 8'h35, 8'h20,
    8'h3a, 8'h20, 8'h30, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00
  };

  desc_t            desc;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  result_t          out;

  logic             advance, at_last, load;
  logic [IDX_W-1:0] last_idx;
  result_t          beat;

  assign empty = !out_valid;
  assign result = out;

  always_comb begin
    case (desc.kind)
      KIND_VERSION: last_idx = VERSION_LAST;
      KIND_STATUS: last_idx = STATUS_LAST;
      default: last_idx = '0;
    endcase
  end

  assign advance = busy && (!out_valid || pop);
  assign at_last = (idx == last_idx);
  assign load = q_valid && (!busy || (advance && at_last));
  assign q_pop = load;

  always_comb begin
    beat.has_data = 1'b1;
    beat.last = at_last;
    beat.data_byte = '0;
    case (desc.kind)
      KIND_VERSION: beat.data_byte = VERSION_TABLE[idx];
      KIND_ACK: beat.has_data = 1'b0;
      KIND_STATUS: begin
        case (idx[3:0])
          4'd0: beat.data_byte = desc.card_in ? 8'd2 : 8'd1;
          4'd1: beat.data_byte = desc.sensor ? SENSOR_CARD : 8'h00;
          4'd2: beat.data_byte = desc.card_id[63:56];
          4'd3: beat.data_byte = desc.card_id[55:48];
          4'd4: beat.data_byte = desc.card_id[47:40];
          4'd5: beat.data_byte = desc.card_id[39:32];
          4'd6: beat.data_byte = desc.card_id[31:24];
          4'd7: beat.data_byte = desc.card_id[23:16];
          4'd8: beat.data_byte = desc.card_id[15:8];
          4'd9: beat.data_byte = desc.card_id[7:0];
          4'd11: beat.data_byte = 8'd3;
          4'd12: beat.data_byte = desc.newest_event;
          4'd13: beat.data_byte = desc.older_event;
          default: beat.data_byte = 8'h00;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) out <= beat;
    if (load) desc <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (advance) begin
        out_valid <= 1'b1;
        if (at_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      // The next command is loaded in the cycle the last beat of the one before is registered.
      if (load) begin
        busy <= 1'b1;
        idx <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/card_reader_command_responder.sv]
// Top level of the card reader command responder: configuration port and the front/back pair.
//
// Commands enter through push/full: a command beat is taken at an edge with push high
// and full low. Responses leave through empty/pop as a run of byte beats, oldest first;
// last marks the final beat of a command. A version command gives 44 beats, a poll
// gives 16, an acknowledgement gives one beat with has_data low, anything else one zero.
// The front updates the reader state and classifies a command in the cycle it is taken
// and writes it into a two-entry queue. The back loads a command from the queue and,
// while the output register is empty or popped, emits one beat per cycle from its byte
// counter into that register; a command passes the queue, the back's descriptor and the
// output register, and the back loads the next one as the last beat enters the register.
// When pop is held low the output register holds its beat, the back waits, and once the
// queue is full, full rises; nothing is lost. The card id register is written through
// the APB port at byte addresses 0 to 7 and reads back there. Reset clears the reader
// state, the queue, the output valid flag and the card id; the output data is not reset.
`default_nettype none

module card_reader_command_responder
  import crcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire command_t    cmd,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] card_id;
  logic        q_full, q_push, q_valid, q_pop;
  desc_t       q_wr_data, q_rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? card_id : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      card_id <= '0;
    end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
      card_id <= pwdata;
    end
  end

  crcr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd     (cmd),
    .card_id (card_id),
    .q_full  (q_full),
    .full    (full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  crcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  crcr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire
